// File: rtl/chained_hash_map_assert.svh
// assertion macros used by chm_dp
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH

// property must hold at every edge out of reset
`define CHM_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("chm invariant violated");

// antecedent implies consequent on the following edge
`define CHM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chm sequence violated");

`endif

// File: rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// shared codes and controller/datapath interface types of the hash map
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 11;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // controller to datapath strobes
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic mod_step;
        logic head_rd;
        logic head_take;
        logic walk_rd;
        logic walk_cmp;
        logic alloc_rd;
        logic act;
        logic act2;
        logic out_load;
    } chm_cmd_t;

    // datapath to controller flags
    typedef struct packed {
        logic             clr_done;
        logic             mod_done;
        logic             cur_live;
        logic             steps_done;
        logic             key_match;
        logic             found;
        logic             free_valid;
        logic             out_free;
        logic [CMD_W-1:0] cmd;
    } chm_stat_t;

endpackage

// File: rtl/chained_hash_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map
// 32-bit key to 32-bit value map, separate chaining over a fixed entry pool
// ----------------------------------------------------------------------------
// After reset the block clears its bucket head memory, one bucket per cycle
// (BUCKETS buckets, 1023 by default), and takes no transfer until that pass
// is done. Each command then hashes the key (key mod BUCKETS by a reciprocal
// multiply, a back multiply and one correcting subtract), reads the bucket
// head (S_HEAD, S_HWAIT), visits each chain entry in turn (registered memory
// read, then key compare) and on a miss sees the end of the chain in S_WALK,
// then passes a decision state, the update states (S_ARD and S_ACT, S_ACT
// alone, or S_ACT and S_ACT2, as the command needs) and a state that loads
// the result register once the output register is free. An unused command
// code skips the hash and the walk. One command is handled at a time; the
// next input is taken while the previous result still waits in the output
// register.
module chained_hash_map #(
    parameter int BUCKETS = 1023,
    parameter int ENTRIES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // command transfer
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [1:0] command, [33:2] key, [65:34] new_value, rest zero
    input  logic [chm_pkg::S_DATA_W-1:0] s_tdata,
    // result transfer
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] found, [32:1] read_value, [33] status, [44:34] entry_count, rest zero
    output logic [chm_pkg::M_DATA_W-1:0] m_tdata
);
    import chm_pkg::*;

    chm_cmd_t  cmd;   // strobes from sequencer
    chm_stat_t st;    // flags back from datapath

    // sequencer: clear pass, hashing, chain walk, update, result hand-off
    chm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // memories, pool bookkeeping and output register
    chm_dp #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// File: rtl/chm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ctrl
// sequencer for clear, bucket hash, chain walk and update of the hash map
// ----------------------------------------------------------------------------
module chm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  chm_pkg::chm_stat_t st,
    output chm_pkg::chm_cmd_t  cmd
);
    import chm_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_HEAD   = 4'd3;
    localparam logic [3:0] S_HWAIT  = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_ARD    = 4'd8;
    localparam logic [3:0] S_ACT    = 4'd9;
    localparam logic [3:0] S_ACT2   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MOD;
                end
            end
            S_MOD: begin
                if (st.cmd == CMD_NOP) begin
                    state_next = S_DONE;
                end else begin
                    cmd.mod_step = 1'b1;
                    if (st.mod_done) state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_HWAIT;
            end
            S_HWAIT: begin
                cmd.head_take = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK: begin
                if (!st.cur_live || st.steps_done) begin
                    state_next = S_DECIDE;
                end else begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP: begin
                cmd.walk_cmp = 1'b1;
                state_next   = st.key_match ? S_DECIDE : S_WALK;
            end
            S_DECIDE: begin
                case (st.cmd)
                    CMD_SET:    state_next = (!st.found && st.free_valid) ? S_ARD : S_ACT;
                    CMD_REMOVE: state_next = st.found ? S_ACT : S_DONE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_ARD: begin
                cmd.alloc_rd = 1'b1;
                state_next   = S_ACT;
            end
            S_ACT: begin
                cmd.act    = 1'b1;
                state_next = (st.cmd == CMD_REMOVE) ? S_ACT2 : S_DONE;
            end
            S_ACT2: begin
                cmd.act2   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

// File: rtl/chm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_dp
// bucket and entry memories, chain pointers, pool bookkeeping, result register
// ----------------------------------------------------------------------------
module chm_dp #(
    parameter int BUCKETS = 1023,
    parameter int ENTRIES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [chm_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [chm_pkg::M_DATA_W-1:0] m_tdata,
    input  chm_pkg::chm_cmd_t           cmd,
    output chm_pkg::chm_stat_t          st
);
    import chm_pkg::*;
    `include "chained_hash_map_assert.svh"

    localparam int LW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(ENTRIES);
    localparam int BW = $clog2(BUCKETS);
    localparam int MOD_STEPS = 3;
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);
    // floor(2^32 / BUCKETS): quotient estimate is exact or one low
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(BUCKETS));
    localparam logic [KEY_W-1:0] BK = KEY_W'(BUCKETS);

    logic [31:0]   key_mem  [ENTRIES];
    logic [31:0]   val_mem  [ENTRIES];
    logic [LW-1:0] link_mem [ENTRIES];
    logic [LW-1:0] head_mem [BUCKETS];

    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] nval_reg, hit_val_reg;
    logic [BW-1:0]    rem_reg;
    logic [2*KEY_W-1:0] prod_reg;
    logic [KEY_W-1:0] qb_reg;
    logic [2:0]       mod_cnt_reg;
    logic [BW-1:0]    clr_reg;
    logic [LW-1:0]    cur_reg, prev_reg, hit_reg, hit_link_reg, steps_reg;
    logic [LW-1:0]    free_reg, fresh_reg, live_reg;
    logic             found_reg, full_reg;
    logic [LW-1:0]    head_q, link_q;
    logic [31:0]      key_q, val_q;
    logic             out_valid_reg;
    logic [M_DATA_W-1:0] out_reg;

    logic [KEY_W-1:0] mod_diff;
    logic          free_valid, fresh_ok, slot_ok, set_miss, is_set, is_rem;
    logic [LW-1:0] slot;
    logic [BW-1:0] bucket;
    logic [31:0]   count_ext;

    // key minus estimated quotient times BUCKETS, below 2*BUCKETS
    assign mod_diff = key_reg - qb_reg;

    assign bucket     = rem_reg;
    assign free_valid = free_reg < NIL;
    assign fresh_ok   = fresh_reg < NIL;
    assign slot_ok    = free_valid || fresh_ok;
    assign slot       = free_valid ? free_reg : fresh_reg;
    assign is_set     = cmd_reg == CMD_SET;
    assign is_rem     = cmd_reg == CMD_REMOVE;
    assign set_miss   = is_set && !found_reg;

    assign st.clr_done   = clr_reg == BW'(BUCKETS - 1);
    assign st.mod_done   = mod_cnt_reg == 3'(MOD_STEPS - 1);
    assign st.cur_live   = cur_reg < NIL;
    assign st.steps_done = steps_reg == NIL;
    assign st.key_match  = key_q == key_reg;
    assign st.found      = found_reg;
    assign st.free_valid = free_valid;
    assign st.out_free   = !out_valid_reg || m_tready;
    assign st.cmd        = cmd_reg;

    // bucket head memory
    always_ff @(posedge aclk) begin
        if (cmd.head_rd) head_q <= head_mem[bucket];
        if (cmd.clr_step) begin
            head_mem[clr_reg] <= NIL;
        end else if (cmd.act && set_miss && slot_ok) begin
            head_mem[bucket] <= slot;
        end else if (cmd.act && is_rem && !(prev_reg < NIL)) begin
            head_mem[bucket] <= hit_link_reg;
        end
    end

    // entry memories
    always_ff @(posedge aclk) begin
        if (cmd.walk_rd) begin
            key_q <= key_mem[cur_reg[AW-1:0]];
            val_q <= val_mem[cur_reg[AW-1:0]];
        end
        if (cmd.walk_rd) begin
            link_q <= link_mem[cur_reg[AW-1:0]];
        end else if (cmd.alloc_rd) begin
            link_q <= link_mem[free_reg[AW-1:0]];
        end
        if (cmd.act && set_miss && slot_ok) begin
            key_mem[slot[AW-1:0]] <= key_reg;
        end
        if (cmd.act && is_set && (found_reg || slot_ok)) begin
            val_mem[found_reg ? hit_reg[AW-1:0] : slot[AW-1:0]] <= nval_reg;
        end
        if (cmd.act && set_miss && slot_ok) begin
            link_mem[slot[AW-1:0]] <= head_q;
        end else if (cmd.act && is_rem) begin
            link_mem[hit_reg[AW-1:0]] <= free_reg;
        end else if (cmd.act2 && (prev_reg < NIL)) begin
            link_mem[prev_reg[AW-1:0]] <= hit_link_reg;
        end
    end

    // per-command payload and walk pointers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg   <= s_tdata[CMD_W-1:0];
            key_reg   <= s_tdata[CMD_W+KEY_W-1:CMD_W];
            nval_reg  <= s_tdata[CMD_W+KEY_W+VAL_W-1:CMD_W+KEY_W];
        end else if (cmd.mod_step) begin
            // reciprocal multiply, back multiply, one correcting subtract
            case (mod_cnt_reg)
                3'd0:    prod_reg <= {{KEY_W{1'b0}}, key_reg} * {{KEY_W{1'b0}}, RECIP};
                3'd1:    qb_reg   <= prod_reg[2*KEY_W-1:KEY_W] * BK;
                default: rem_reg  <= (mod_diff >= BK) ? BW'(mod_diff - BK) : BW'(mod_diff);
            endcase
        end
        if (cmd.head_take) begin
            cur_reg   <= head_q;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end else if (cmd.walk_cmp && !st.key_match) begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_q;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.walk_cmp && st.key_match) begin
            hit_reg      <= cur_reg;
            hit_link_reg <= link_q;
            hit_val_reg  <= val_q;
        end
    end

    // control state: clear and hash counters, pool bookkeeping, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            mod_cnt_reg   <= '0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            free_reg      <= NIL;
            fresh_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step && !st.clr_done) clr_reg <= clr_reg + 1'b1;
            if (cmd.load_in) begin
                mod_cnt_reg <= '0;
                found_reg   <= 1'b0;
                full_reg    <= 1'b0;
            end else if (cmd.mod_step) begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (cmd.walk_cmp && st.key_match) found_reg <= 1'b1;
            if (cmd.act && set_miss) begin
                if (free_valid) begin
                    free_reg <= link_q;
                end else if (fresh_ok) begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
                if (slot_ok) live_reg <= live_reg + 1'b1;
                full_reg <= !slot_ok;
            end else if (cmd.act && is_rem && found_reg) begin
                free_reg <= hit_reg;
                if (live_reg != '0) live_reg <= live_reg - 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = 32'(live_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= {3'b000, count_ext[COUNT_W-1:0], full_reg,
                        (cmd_reg == CMD_LOOKUP && found_reg) ? hit_val_reg : 32'd0,
                        found_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `CHM_ASSERT_ALWAYS(a_live_le_fresh, live_reg <= fresh_reg)
    `CHM_ASSERT_ALWAYS(a_fresh_bound, fresh_reg <= NIL)
    `CHM_ASSERT_NEXT(a_cmp_hit_found, cmd.walk_cmp && st.key_match, found_reg)
    `CHM_ASSERT_ALWAYS(a_walk_live, !cmd.walk_rd || (cur_reg < NIL))

endmodule
